// File: rtl/core/osm_pkg.sv
// Shared constants, request codes and queue word type for the one-shot sample mixer.
package osm_pkg;

    localparam int TAKE_COUNT_DEF  = 4;
    localparam int STORE_DEPTH_DEF = 65536;

    localparam int SMP_W  = 16;
    localparam int LEN_W  = 17;
    localparam int VOL_W  = 8;
    localparam int IDX_IN_W = 2;

    localparam logic [VOL_W-1:0] VOLUME_MAX = 8'd200;
    localparam int GAIN_DIVISOR = 100;

    // scaled = trunc(prod / 100) via |prod| * RECIP >> RECIP_SHIFT, exact for |prod| < 2^23
    localparam int RECIP_SHIFT = 30;
    localparam longint RECIP_VAL = ((64'd1 << RECIP_SHIFT) + GAIN_DIVISOR - 1) / GAIN_DIVISOR;
    localparam int RECIP_W = 24;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_VAL[RECIP_W-1:0];

    localparam logic signed [SMP_W-1:0] SAT_HIGH = 16'sh7fff;
    localparam logic signed [SMP_W-1:0] SAT_LOW  = -16'sh8000;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        REQ_MIX     = 2'd0,
        REQ_TRIGGER = 2'd1,
        REQ_SAMPLE  = 2'd2,
        REQ_TAKE    = 2'd3
    } req_t;

    // one mix frame handed from front to back
    typedef struct packed {
        logic signed [SMP_W-1:0] left;
        logic signed [SMP_W-1:0] right;
        logic signed [SMP_W-1:0] sample;  // zero when nothing plays
        logic [VOL_W-1:0]        vol;
        logic                    mixed;
    } mix_word_t;

endpackage

// File: rtl/core/one_shot_sample_mixer_core.sv
// Top level of the one-shot sample mixer: front end, mix-word queue, back end.
// A mix frame passes the issue register, the queue, b1, b2 and the output register.
// Throughput: one word per cycle unless m_ready is low; the back end's output register paces it.
// Non-mix words (trigger, sample write, take write) finish at their accepting edge, no result.
// Reset (aresetn low, synchronous): play stops, volume 0, take order back to take 0, queue empty.
// Sample store and take starts hold nothing useful until written; take lengths read zero.
module one_shot_sample_mixer_core #(
    parameter int TAKE_COUNT  = osm_pkg::TAKE_COUNT_DEF,
    parameter int STORE_DEPTH = osm_pkg::STORE_DEPTH_DEF   // power of two
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // volume register
    input  logic                              cfg_wr_en,
    input  logic [osm_pkg::VOL_W-1:0]         cfg_wr_data,
    // input words
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [1:0]                        s_req_type,
    input  logic signed [osm_pkg::SMP_W-1:0]  s_left_in,
    input  logic signed [osm_pkg::SMP_W-1:0]  s_right_in,
    input  logic [osm_pkg::IDX_IN_W-1:0]      s_take_index,
    input  logic [15:0]                       s_sample_address,
    input  logic signed [osm_pkg::SMP_W-1:0]  s_sample_value,
    input  logic [15:0]                       s_take_start,
    input  logic [osm_pkg::LEN_W-1:0]         s_take_length,
    // mixed frames
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [osm_pkg::SMP_W-1:0]  m_left_out,
    output logic signed [osm_pkg::SMP_W-1:0]  m_right_out,
    output logic                              m_effect_mixed
);
    import osm_pkg::*;

    logic                 push;
    mix_word_t            push_word;
    logic                 pop;
    logic                 head_valid;
    mix_word_t            head_word;
    logic [QCNT_W-1:0]    q_count;

    // Front end: all state updates happen in arrival order here, and the
    // sample store is read on the frame's accepting edge. s_ready holds off
    // only when the queue plus the word in flight could fill it.
    osm_front #(
        .TAKE_COUNT  (TAKE_COUNT),
        .STORE_DEPTH (STORE_DEPTH)
    ) u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_req_type       (s_req_type),
        .s_left_in        (s_left_in),
        .s_right_in       (s_right_in),
        .s_take_index     (s_take_index),
        .s_sample_address (s_sample_address),
        .s_sample_value   (s_sample_value),
        .s_take_start     (s_take_start),
        .s_take_length    (s_take_length),
        .q_count          (q_count),
        .push             (push),
        .push_word        (push_word)
    );

    // Queue decouples a stalled output from the front end.
    osm_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_word  (push_word),
        .pop        (pop),
        .head_valid (head_valid),
        .head_word  (head_word),
        .count      (q_count)
    );

    // Back end: multiply, reciprocal divide, saturating add; stalls as a unit.
    osm_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .head_valid     (head_valid),
        .head_word      (head_word),
        .pop            (pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_left_out     (m_left_out),
        .m_right_out    (m_right_out),
        .m_effect_mixed (m_effect_mixed)
    );

endmodule

// File: rtl/core/osm_queue.sv
// Short FIFO of mix words between the front and back ends.
module osm_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  osm_pkg::mix_word_t push_word,
    input  logic               pop,
    output logic               head_valid,
    output osm_pkg::mix_word_t head_word,
    output logic [osm_pkg::QCNT_W-1:0] count
);
    import osm_pkg::*;

    mix_word_t             buf_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]     count_reg, count_next;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            buf_reg[wr_ptr_reg] <= push_word;
        end
    end

    assign head_valid = (count_reg != '0);
    assign head_word  = buf_reg[rd_ptr_reg];
    assign count      = count_reg;

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (count_reg < QCNT_W'(QUEUE_DEPTH)) || pop)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> (count_reg != '0))
        else $error("queue pop while empty");

    a_count_track: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |->
            (count_reg == $past(count_reg) + QCNT_W'($past(push)) - QCNT_W'($past(pop))))
        else $error("queue count out of step with push/pop");

endmodule

// File: rtl/core/osm_front.sv
// Front end: accepts words, owns play state, tables and sample store, issues mix words.
module osm_front #(
    parameter int TAKE_COUNT  = osm_pkg::TAKE_COUNT_DEF,
    parameter int STORE_DEPTH = osm_pkg::STORE_DEPTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [osm_pkg::VOL_W-1:0]         cfg_wr_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [1:0]                        s_req_type,
    input  logic signed [osm_pkg::SMP_W-1:0]  s_left_in,
    input  logic signed [osm_pkg::SMP_W-1:0]  s_right_in,
    input  logic [osm_pkg::IDX_IN_W-1:0]      s_take_index,
    input  logic [15:0]                       s_sample_address,
    input  logic signed [osm_pkg::SMP_W-1:0]  s_sample_value,
    input  logic [15:0]                       s_take_start,
    input  logic [osm_pkg::LEN_W-1:0]         s_take_length,
    input  logic [osm_pkg::QCNT_W-1:0]        q_count,
    output logic                              push,
    output osm_pkg::mix_word_t                push_word
);
    import osm_pkg::*;

    localparam int TIDX_W = (TAKE_COUNT > 1) ? $clog2(TAKE_COUNT) : 1;
    localparam int ADDR_W = $clog2(STORE_DEPTH);

    // play state
    logic [VOL_W-1:0]   vol_reg, vol_next;
    logic               playing_reg, playing_next;
    logic [LEN_W-1:0]   pos_reg, pos_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [15:0]        start_reg, start_next;
    logic [TIDX_W-1:0]  next_idx_reg, next_idx_next;

    // take table, registered read at the upcoming take index
    logic [15:0]           start_tbl [TAKE_COUNT];
    logic [LEN_W-1:0]      len_tbl   [TAKE_COUNT];
    logic [TAKE_COUNT-1:0] len_valid_reg;
    logic [15:0]           start_rd_reg;
    logic [LEN_W-1:0]      len_rd_reg;
    logic [TIDX_W-1:0]     take_rd_idx;

    // sample store
    logic signed [SMP_W-1:0] store_mem [STORE_DEPTH];
    logic signed [SMP_W-1:0] rd_data_reg;

    // issue stage
    logic                    f1_valid_reg;
    logic signed [SMP_W-1:0] f1_left_reg, f1_right_reg;
    logic [VOL_W-1:0]        f1_vol_reg;
    logic                    f1_hit_reg;

    logic               acc;
    req_t               req;
    logic               hit;
    logic [LEN_W-1:0]   pos_inc;
    logic [LEN_W:0]     play_sum;
    logic               store_we, store_re;
    logic               tbl_we;
    logic [TIDX_W-1:0]  tbl_wi;
    logic [VOL_W-1:0]   vol_clamped;

    // credit: an accepted mix word needs a queue slot in the cycle after it is accepted
    assign s_ready = ({1'b0, q_count} + (QCNT_W+1)'(f1_valid_reg)) < (QCNT_W+1)'(QUEUE_DEPTH);
    assign acc     = s_valid && s_ready;
    assign req     = req_t'(s_req_type);
    assign hit     = playing_reg && (pos_reg < len_reg);
    assign pos_inc = pos_reg + 1'b1;
    assign play_sum = (LEN_W+1)'(start_reg) + (LEN_W+1)'(pos_reg);
    assign tbl_wi  = TIDX_W'(s_take_index);
    assign vol_clamped = (cfg_wr_data > VOLUME_MAX) ? VOLUME_MAX : cfg_wr_data;

    always_comb begin
        vol_next      = vol_reg;
        playing_next  = playing_reg;
        pos_next      = pos_reg;
        len_next      = len_reg;
        start_next    = start_reg;
        next_idx_next = next_idx_reg;
        store_we      = 1'b0;
        store_re      = 1'b0;
        tbl_we        = 1'b0;
        if (acc) begin
            case (req)
                REQ_MIX: begin
                    if (hit) begin
                        store_re = 1'b1;
                        if (pos_inc >= len_reg) begin
                            playing_next = 1'b0;
                            pos_next     = '0;
                            len_next     = '0;
                        end else begin
                            pos_next = pos_inc;
                        end
                    end
                end
                REQ_TRIGGER: begin
                    if (vol_reg != '0) begin
                        start_next   = start_rd_reg;
                        len_next     = len_rd_reg;
                        pos_next     = '0;
                        playing_next = 1'b1;
                        next_idx_next = (next_idx_reg == TIDX_W'(TAKE_COUNT - 1)) ?
                                        '0 : next_idx_reg + 1'b1;
                    end
                end
                REQ_SAMPLE: begin
                    store_we = 1'b1;
                end
                REQ_TAKE: begin
                    tbl_we = (32'(s_take_index) < TAKE_COUNT);
                end
                default: begin
                end
            endcase
        end
        if (cfg_wr_en) begin
            vol_next = vol_clamped;
            if (vol_clamped == '0) begin
                playing_next = 1'b0;
                pos_next     = '0;
                len_next     = '0;
            end
        end
    end

    assign take_rd_idx = aresetn ? next_idx_next : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vol_reg      <= '0;
            playing_reg  <= 1'b0;
            pos_reg      <= '0;
            len_reg      <= '0;
            start_reg    <= '0;
            next_idx_reg <= '0;
            f1_valid_reg <= 1'b0;
        end else begin
            vol_reg      <= vol_next;
            playing_reg  <= playing_next;
            pos_reg      <= pos_next;
            len_reg      <= len_next;
            start_reg    <= start_next;
            next_idx_reg <= next_idx_next;
            f1_valid_reg <= acc && (req == REQ_MIX);
        end
    end

    always_ff @(posedge aclk) begin
        if (acc) begin
            f1_left_reg  <= s_left_in;
            f1_right_reg <= s_right_in;
            f1_vol_reg   <= vol_reg;
            f1_hit_reg   <= hit;
        end
    end

    // take table: write port plus registered read with same-cycle forwarding
    always_ff @(posedge aclk) begin
        if (tbl_we) begin
            start_tbl[tbl_wi] <= s_take_start;
            len_tbl[tbl_wi]   <= s_take_length;
        end
        if (tbl_we && (tbl_wi == take_rd_idx)) begin
            start_rd_reg <= s_take_start;
        end else begin
            start_rd_reg <= start_tbl[take_rd_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_valid_reg <= '0;
            len_rd_reg    <= '0;
        end else begin
            if (tbl_we) begin
                len_valid_reg[tbl_wi] <= 1'b1;
            end
            if (tbl_we && (tbl_wi == take_rd_idx)) begin
                len_rd_reg <= s_take_length;
            end else if (len_valid_reg[take_rd_idx]) begin
                len_rd_reg <= len_tbl[take_rd_idx];
            end else begin
                len_rd_reg <= '0;
            end
        end
    end

    // sample store: one write, one registered read
    always_ff @(posedge aclk) begin
        if (store_we) begin
            store_mem[ADDR_W'(s_sample_address)] <= s_sample_value;
        end
        if (store_re) begin
            rd_data_reg <= store_mem[ADDR_W'(play_sum)];
        end
    end

    assign push             = f1_valid_reg;
    assign push_word.left   = f1_left_reg;
    assign push_word.right  = f1_right_reg;
    assign push_word.sample = f1_hit_reg ? rd_data_reg : '0;
    assign push_word.vol    = f1_vol_reg;
    assign push_word.mixed  = f1_hit_reg;

endmodule

// File: rtl/core/osm_back.sv
// Back end: gain multiply, divide by 100, saturating add into both channels.
module osm_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              head_valid,
    input  osm_pkg::mix_word_t                head_word,
    output logic                              pop,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [osm_pkg::SMP_W-1:0]  m_left_out,
    output logic signed [osm_pkg::SMP_W-1:0]  m_right_out,
    output logic                              m_effect_mixed
);
    import osm_pkg::*;

    localparam int PROD_W = SMP_W + VOL_W + 1;
    localparam int MAG_W  = PROD_W - 1;
    localparam int QP_W   = MAG_W + RECIP_W;
    localparam int Q_W    = QP_W - RECIP_SHIFT;
    localparam int SUM_W  = Q_W + 2;

    logic                     en;

    logic                     b1_valid_reg;
    logic signed [PROD_W-1:0] b1_prod_reg;
    logic signed [SMP_W-1:0]  b1_left_reg, b1_right_reg;
    logic                     b1_mixed_reg;

    logic                     b2_valid_reg;
    logic [QP_W-1:0]          b2_qp_reg;
    logic                     b2_neg_reg;
    logic signed [SMP_W-1:0]  b2_left_reg, b2_right_reg;
    logic                     b2_mixed_reg;

    logic                     m_valid_reg;
    logic signed [SMP_W-1:0]  m_left_reg, m_right_reg;
    logic                     m_mixed_reg;

    logic [MAG_W-1:0]         b1_mag;
    logic [Q_W-1:0]           quot;
    logic signed [SUM_W-1:0]  scaled;
    logic signed [SUM_W-1:0]  sum_l, sum_r;

    function automatic logic signed [SMP_W-1:0] sat16(input logic signed [SUM_W-1:0] v);
        if (v > SUM_W'(SAT_HIGH)) begin
            return SAT_HIGH;
        end else if (v < SUM_W'(SAT_LOW)) begin
            return SAT_LOW;
        end
        return SMP_W'(v);
    endfunction

    assign en  = !m_valid_reg || m_ready;
    assign pop = en && head_valid;

    assign b1_mag = b1_prod_reg[PROD_W-1] ? MAG_W'(-b1_prod_reg) : MAG_W'(b1_prod_reg);
    assign quot   = b2_qp_reg[QP_W-1:RECIP_SHIFT];
    assign scaled = b2_neg_reg ? -$signed(SUM_W'(quot)) : $signed(SUM_W'(quot));
    assign sum_l  = SUM_W'(b2_left_reg) + scaled;
    assign sum_r  = SUM_W'(b2_right_reg) + scaled;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b1_valid_reg <= 1'b0;
            b2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else if (en) begin
            b1_valid_reg <= head_valid;
            b2_valid_reg <= b1_valid_reg;
            m_valid_reg  <= b2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b1_prod_reg  <= PROD_W'(head_word.sample) * $signed({1'b0, head_word.vol});
            b1_left_reg  <= head_word.left;
            b1_right_reg <= head_word.right;
            b1_mixed_reg <= head_word.mixed;

            b2_qp_reg    <= QP_W'(b1_mag) * QP_W'(RECIP);
            b2_neg_reg   <= b1_prod_reg[PROD_W-1];
            b2_left_reg  <= b1_left_reg;
            b2_right_reg <= b1_right_reg;
            b2_mixed_reg <= b1_mixed_reg;

            m_left_reg   <= sat16(sum_l);
            m_right_reg  <= sat16(sum_r);
            m_mixed_reg  <= b2_mixed_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_left_out     = m_left_reg;
    assign m_right_out    = m_right_reg;
    assign m_effect_mixed = m_mixed_reg;

endmodule
